[hdl/mlvnf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlvnf_pkg
// Shared types, codes and helpers for the low-velocity note filter.
// ----------------------------------------------------------------------------
package mlvnf_pkg;

   localparam int KEY_COUNT = 128;
   localparam int KEY_W     = $clog2(KEY_COUNT);

   localparam int COUNT_W   = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int DELTA_IN_W  = 28;
   localparam int DELTA_OUT_W = 32;
   localparam int KIND_W      = 4;
   localparam int CHAN_W      = 4;
   localparam int KEYNUM_W    = 8;
   localparam int VALUE_W     = 14;
   localparam int THRESH_W    = 8;
   localparam int STATUS_W    = 8;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 5;

   localparam logic [KIND_W-1:0] KIND_NOTEOFF  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_NOTEON   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_PROGRAM  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_PRESSURE = 4'd5;
   localparam logic [KIND_W-1:0] KIND_BEND     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_SYSEX    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_META     = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_NONE  = 8'h00;
   localparam logic [STATUS_W-1:0] STATUS_SYSEX = 8'hF0;
   localparam logic [STATUS_W-1:0] STATUS_META  = 8'hFF;

   typedef logic [KEY_W-1:0]   key_idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic        en;
      key_idx_type idx;
      count_type   value;
   } cnt_wr_type;

   function automatic logic [STATUS_W-1:0] status_of(input logic [KIND_W-1:0] kind,
                                                     input logic [CHAN_W-1:0] chan);
      logic [STATUS_W-1:0] st;
      if (kind == KIND_SYSEX) begin
         st = STATUS_SYSEX;
      end else if (kind == KIND_META) begin
         st = STATUS_META;
      end else begin
         st = {1'b1, kind[2:0], chan};
      end
      return st;
   endfunction

endpackage
`default_nettype wire

[hdl/mlvnf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlvnf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlvnf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/mlvnf_key_counts.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlvnf_key_counts
// Per-key drop counters: RAM with per-entry valid bits that clear a track at
// once, and a bypass of the last write for back-to-back updates.
// ----------------------------------------------------------------------------
module mlvnf_key_counts (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    rd_en,
   input  wire mlvnf_pkg::key_idx_type  rd_idx,
   input  wire mlvnf_pkg::key_idx_type  look_idx,
   input  wire logic                    clear,
   input  wire mlvnf_pkg::cnt_wr_type   wr,
   output mlvnf_pkg::count_type         count
);
   import mlvnf_pkg::*;

   logic [KEY_COUNT-1:0] valid_ff;
   logic [KEY_COUNT-1:0] valid_in;
   cnt_wr_type           fwd_ff;
   cnt_wr_type           fwd_in;
   count_type            ram_data;

   mlvnf_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(KEY_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.idx),
      .wr_data(wr.value),
      .rd_en  (rd_en),
      .rd_addr(rd_idx),
      .rd_data(ram_data)
   );

   always_comb begin
      valid_in = clear ? '0 : valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
      fwd_in = fwd_ff;
      if (wr.en) begin
         fwd_in = wr;
      end else if (clear) begin
         fwd_in.en = 1'b0;
      end
   end

   always_comb begin
      if (fwd_ff.en && fwd_ff.idx == look_idx) begin
         count = fwd_ff.value;
      end else if (valid_ff[look_idx]) begin
         count = ram_data;
      end else begin
         count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         fwd_ff.en <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         fwd_ff.en <= fwd_in.en;
      end
      fwd_ff.idx   <= fwd_in.idx;
      fwd_ff.value <= fwd_in.value;
   end

   assert property (@(posedge clock) disable iff (reset)
      wr.en |=> valid_ff[$past(wr.idx)])
      else $error("written count not marked valid");

   assert property (@(posedge clock) disable iff (reset)
      fwd_ff.en |-> valid_ff[fwd_ff.idx])
      else $error("bypass entry points at a cleared key");

   assert property (@(posedge clock) disable iff (reset)
      clear && !wr.en |=> !fwd_ff.en)
      else $error("bypass entry survived a track clear");

endmodule
`default_nettype wire

[hdl/midi_low_velocity_note_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_low_velocity_note_filter
// Drops quiet note-ons and their matching note-offs from a parsed MIDI
// event stream, folding dropped delta times into the next kept event.
// ----------------------------------------------------------------------------
// Takes one event per clock unless a kept event waits on a busy result
// register. The event is registered with its per-key count RAM read, then
// the decision loads the result register. Back-to-back events on the same
// key see the previous update through a write bypass. A track start clears
// all key counts at once through per-key valid bits, so there is no clearing
// pass after reset. Dropped events and unknown kinds yield no output transfer.
// ----------------------------------------------------------------------------
module midi_low_velocity_note_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [mlvnf_pkg::THRESH_W-1:0]    csr_wr_data,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // delta_time[27:0], channel[31:28], key_number[39:32], data_value[53:40]
   input  wire logic [mlvnf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // track_start[0], event_kind[4:1]
   input  wire logic [mlvnf_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_delta[31:0], out_channel[35:32], out_key[43:36], out_value[57:44]
   output logic [mlvnf_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // emit_status[0], out_kind[4:1]
   output logic [mlvnf_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import mlvnf_pkg::*;

   logic [THRESH_W-1:0]    thresh_ff;

   logic                   s1_valid_ff;
   logic                   s1_start_ff;
   logic [DELTA_IN_W-1:0]  s1_delta_ff;
   logic [KIND_W-1:0]      s1_kind_ff;
   logic [CHAN_W-1:0]      s1_chan_ff;
   logic [KEYNUM_W-1:0]    s1_key_ff;
   logic [VALUE_W-1:0]     s1_value_ff;

   logic [DELTA_OUT_W-1:0] carried_ff;
   logic [DELTA_OUT_W-1:0] carried_in;
   logic [STATUS_W-1:0]    last_ff;
   logic [STATUS_W-1:0]    last_in;

   logic                   rsp_valid_ff;
   logic [DELTA_OUT_W-1:0] rsp_delta_ff;
   logic                   rsp_emit_ff;
   logic [KIND_W-1:0]      rsp_kind_ff;
   logic [CHAN_W-1:0]      rsp_chan_ff;
   logic [KEYNUM_W-1:0]    rsp_key_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;

   logic                   req_xfer;
   logic                   out_free;
   logic                   advance;
   logic [DELTA_OUT_W-1:0] base_delta;
   logic [STATUS_W-1:0]    base_last;
   logic [DELTA_OUT_W-1:0] tick;
   logic                   known;
   logic                   slot;
   logic                   quiet;
   logic                   drop_on;
   logic                   drop_off;
   logic                   keep;
   logic                   sys_or_meta;
   logic [STATUS_W-1:0]    status;
   logic                   emit;
   count_type              store_count;
   count_type              count;
   cnt_wr_type             cnt_wr;
   logic                   cnt_clear;
   logic [CHAN_W-1:0]      kept_chan;
   logic [KEYNUM_W-1:0]    kept_key;
   logic [VALUE_W-1:0]     kept_value;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign base_delta  = s1_start_ff ? '0 : carried_ff;
   assign base_last   = s1_start_ff ? STATUS_NONE : last_ff;
   assign tick        = base_delta + {{(DELTA_OUT_W-DELTA_IN_W){1'b0}}, s1_delta_ff};
   assign known       = s1_kind_ff <= KIND_META;
   assign slot        = {1'b0, s1_key_ff} < (KEYNUM_W+1)'(KEY_COUNT);
   assign count       = s1_start_ff ? '0 : store_count;
   assign quiet       = $signed({1'b0, s1_value_ff})
                        <= $signed({{(VALUE_W+1-THRESH_W){thresh_ff[THRESH_W-1]}}, thresh_ff});
   assign drop_on     = known && s1_kind_ff == KIND_NOTEON && quiet;
   assign drop_off    = known && s1_kind_ff == KIND_NOTEOFF && slot && count != '0;
   assign keep        = known && !drop_on && !drop_off;
   assign advance     = s1_valid_ff && (!keep || out_free);
   assign sys_or_meta = s1_kind_ff == KIND_SYSEX || s1_kind_ff == KIND_META;
   assign status      = status_of(s1_kind_ff, s1_chan_ff);
   assign emit        = sys_or_meta || status != base_last;

   assign cnt_clear    = advance && s1_start_ff;
   assign cnt_wr.en    = advance && slot && ((drop_on && count != COUNT_MAX) || drop_off);
   assign cnt_wr.idx   = s1_key_ff[KEY_W-1:0];
   assign cnt_wr.value = drop_on ? count + 1'b1 : count - 1'b1;

   assign kept_chan  = sys_or_meta ? '0 : s1_chan_ff;
   assign kept_key   = (s1_kind_ff == KIND_PROGRAM || s1_kind_ff == KIND_PRESSURE ||
                        s1_kind_ff == KIND_BEND || s1_kind_ff == KIND_SYSEX) ? '0 : s1_key_ff;
   assign kept_value = sys_or_meta ? '0 : s1_value_ff;

   always_comb begin
      carried_in = carried_ff;
      last_in    = last_ff;
      if (advance) begin
         if (!known) begin
            carried_in = base_delta;
         end else if (keep) begin
            carried_in = '0;
         end else begin
            carried_in = tick;
         end
         last_in = (keep && emit) ? status : base_last;
      end
   end

   mlvnf_key_counts u_key_counts (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_idx  (req_tdata[32 +: KEY_W]),
      .look_idx(s1_key_ff[KEY_W-1:0]),
      .clear   (cnt_clear),
      .wr      (cnt_wr),
      .count   (store_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         carried_ff   <= '0;
         last_ff      <= STATUS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            thresh_ff <= csr_wr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         carried_ff <= carried_in;
         last_ff    <= last_in;
         if (advance && keep) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_xfer) begin
         s1_start_ff <= req_tuser[0];
         s1_kind_ff  <= req_tuser[4:1];
         s1_delta_ff <= req_tdata[27:0];
         s1_chan_ff  <= req_tdata[31:28];
         s1_key_ff   <= req_tdata[39:32];
         s1_value_ff <= req_tdata[53:40];
      end
      if (advance && keep) begin
         rsp_delta_ff <= tick;
         rsp_emit_ff  <= emit;
         rsp_kind_ff  <= s1_kind_ff;
         rsp_chan_ff  <= kept_chan;
         rsp_key_ff   <= kept_key;
         rsp_value_ff <= kept_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DELTA_OUT_W-CHAN_W-KEYNUM_W-VALUE_W){1'b0}},
                        rsp_value_ff, rsp_key_ff, rsp_chan_ff, rsp_delta_ff};
   assign rsp_tuser  = {rsp_kind_ff, rsp_emit_ff};

   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled with empty stage");

   assert property (@(posedge clock) disable iff (reset)
      advance && keep |=> carried_ff == '0)
      else $error("carried delta not consumed by kept event");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && keep))
      else $error("result appeared without a kept event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_SYSEX || rsp_kind_ff == KIND_META) |-> rsp_emit_ff)
      else $error("sysex or meta without status byte");

endmodule
`default_nettype wire

[tb/sv/tb_midi_low_velocity_note_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_low_velocity_note_filter
// Self-checking bench for the low-velocity note filter. Every event that is
// transferred in goes through a cycle-free software filter in the bench, and
// each kept event it yields is queued. Each output transfer is then compared
// field by field with the oldest queued event. The run covers directed corner
// cases, a long output hold-off, randomized note traffic under several
// thresholds and idling mixes, and a long count up and down on one key.
// ----------------------------------------------------------------------------
module tb_midi_low_velocity_note_filter;
   import mlvnf_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int DRAIN_CYCLES   = 6;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int COUNT_RUN      = 40;

   localparam logic [KIND_W-1:0]   KIND_POLYTOUCH = 4'd2;
   localparam logic [KIND_W-1:0]   KIND_CONTROL   = 4'd3;
   localparam logic [KIND_W-1:0]   KIND_UNKNOWN   = 4'd9;
   localparam logic [KIND_W-1:0]   KIND_LAST      = 4'd15;
   localparam logic [STATUS_W-1:0] STATUS_BASE    = 8'h80;

   typedef struct packed {
      logic                  start;
      logic [DELTA_IN_W-1:0] delta;
      logic [KIND_W-1:0]     kind;
      logic [CHAN_W-1:0]     chan;
      logic [KEYNUM_W-1:0]   key;
      logic [VALUE_W-1:0]    value;
   } midi_event_type;

   typedef struct packed {
      logic [DELTA_OUT_W-1:0] delta;
      logic                   emit;
      logic [KIND_W-1:0]      kind;
      logic [CHAN_W-1:0]      chan;
      logic [KEYNUM_W-1:0]    key;
      logic [VALUE_W-1:0]     value;
   } kept_event_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [THRESH_W-1:0]    csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata   = '0;
   logic [REQ_USER_W-1:0]  req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;

   // filter state mirrored by the bench
   logic [COUNT_W-1:0]     drop_count [KEY_COUNT];
   logic [DELTA_OUT_W-1:0] carried_ticks;
   logic [STATUS_W-1:0]    last_status_byte;
   logic signed [THRESH_W-1:0] vel_threshold;

   kept_event_type expected_events[$];
   int          mismatches     = 0;
   int          stall_cycles   = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int          hold_requests  = 0;
   int          holds_seen     = 0;
   int          hold_left      = 0;

   midi_low_velocity_note_filter uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic bit filter_event(input midi_event_type ev, output kept_event_type res);
      logic [DELTA_OUT_W-1:0] tick;
      logic [STATUS_W-1:0]    st;
      logic [KEY_W-1:0]       slot;
      bit                     has_slot;
      int                     vel;
      int                     thr;
      res      = '0;
      has_slot = (ev.key < KEY_COUNT);
      slot     = ev.key[KEY_W-1:0];
      if (ev.start) begin
         foreach (drop_count[i]) drop_count[i] = '0;
         carried_ticks    = '0;
         last_status_byte = STATUS_NONE;
      end
      if (ev.kind > KIND_META) return 1'b0;
      tick = carried_ticks + DELTA_OUT_W'(ev.delta);
      vel  = ev.value;
      thr  = vel_threshold;
      if (ev.kind == KIND_NOTEON && vel <= thr) begin
         if (has_slot && drop_count[slot] != COUNT_MAX) drop_count[slot]++;
         carried_ticks = tick;
         return 1'b0;
      end
      if (ev.kind == KIND_NOTEOFF && has_slot && drop_count[slot] != '0) begin
         drop_count[slot]--;
         carried_ticks = tick;
         return 1'b0;
      end
      carried_ticks = '0;
      if (ev.kind == KIND_SYSEX) begin
         st = STATUS_SYSEX;
      end else if (ev.kind == KIND_META) begin
         st = STATUS_META;
      end else begin
         st = STATUS_BASE + {ev.kind, 4'b0000} + STATUS_W'(ev.chan);
      end
      res.emit = (ev.kind == KIND_SYSEX || ev.kind == KIND_META || st != last_status_byte);
      if (res.emit) last_status_byte = st;
      res.delta = tick;
      res.kind  = ev.kind;
      res.chan  = (ev.kind == KIND_SYSEX || ev.kind == KIND_META) ? '0 : ev.chan;
      res.key   = (ev.kind == KIND_PROGRAM || ev.kind == KIND_PRESSURE ||
                   ev.kind == KIND_BEND || ev.kind == KIND_SYSEX) ? '0 : ev.key;
      res.value = (ev.kind == KIND_SYSEX || ev.kind == KIND_META) ? '0 : ev.value;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      midi_event_type ev;
      kept_event_type want;
      kept_event_type got;
      bit          req_xfer;
      bit          rsp_xfer;
      req_xfer = req_tvalid && req_tready;
      rsp_xfer = rsp_tvalid && rsp_tready;
      if (reset) begin
         foreach (drop_count[i]) drop_count[i] = '0;
         carried_ticks    = '0;
         last_status_byte = STATUS_NONE;
         vel_threshold    = '0;
         stall_cycles     = 0;
      end else begin
         if (csr_wr_en) vel_threshold = csr_wr_data;
         if (req_xfer) begin
            ev.start = req_tuser[0];
            ev.kind  = req_tuser[4:1];
            ev.delta = req_tdata[27:0];
            ev.chan  = req_tdata[31:28];
            ev.key   = req_tdata[39:32];
            ev.value = req_tdata[53:40];
            if (filter_event(ev, want)) expected_events.push_back(want);
         end
         if (rsp_xfer) begin
            got.delta = rsp_tdata[31:0];
            got.chan  = rsp_tdata[35:32];
            got.key   = rsp_tdata[43:36];
            got.value = rsp_tdata[57:44];
            got.emit  = rsp_tuser[0];
            got.kind  = rsp_tuser[4:1];
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected transfer out, expected none, actual 0x%0h",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               check_field("out_delta", want.delta, got.delta);
               check_field("emit_status", want.emit, got.emit);
               check_field("out_kind", want.kind, got.kind);
               check_field("out_channel", want.chan, got.chan);
               check_field("out_key", want.key, got.key);
               check_field("out_value", want.value, got.value);
            end
         end
         stall_cycles = (req_xfer || rsp_xfer) ? 0 : stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("midi_low_velocity_note_filter test failed");
            $finish;
         end
      end
   end

   // output ready: random stalls, plus a long hold when one is requested
   always @(negedge clock) begin
      if (holds_seen != hold_requests) begin
         holds_seen <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic midi_event_type midi_ev(input logic start, input logic [27:0] delta,
                                              input logic [3:0] kind, input logic [3:0] chan,
                                              input logic [7:0] key, input logic [13:0] value);
      midi_event_type ev;
      ev.start = start;
      ev.delta = delta;
      ev.kind  = kind;
      ev.chan  = chan;
      ev.key   = key;
      ev.value = value;
      return ev;
   endfunction

   function automatic midi_event_type random_event();
      midi_event_type ev;
      int          pick;
      int          t;
      ev.start = ($urandom_range(59) == 0);
      ev.delta = ($urandom_range(7) == 0) ? 28'($urandom) : 28'($urandom_range(300));
      ev.chan  = ($urandom_range(3) != 0) ? 4'($urandom_range(1)) : 4'($urandom);
      pick = $urandom_range(19);
      if (pick < 17) ev.key = 8'(60 + $urandom_range(3));
      else if (pick < 19) ev.key = 8'($urandom_range(127));
      else ev.key = 8'($urandom_range(255, 128));
      pick = $urandom_range(99);
      if (pick < 40) ev.kind = KIND_NOTEON;
      else if (pick < 70) ev.kind = KIND_NOTEOFF;
      else if (pick < 95) ev.kind = 4'($urandom_range(KIND_META, KIND_POLYTOUCH));
      else ev.kind = 4'($urandom_range(KIND_LAST, KIND_UNKNOWN));
      pick = $urandom_range(9);
      t = (vel_threshold < 1) ? 1 : vel_threshold;
      if (pick < 4) ev.value = 14'(t - 1 + $urandom_range(2));
      else if (pick < 8) ev.value = 14'($urandom_range(127));
      else ev.value = 14'($urandom);
      return ev;
   endfunction

   task automatic send_event(input midi_event_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ev.value, ev.key, ev.chan, ev.delta};
      req_tuser  <= {ev.kind, ev.start};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic signed [THRESH_W-1:0] thr);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= thr;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_reset_threshold();
      send_event(midi_ev(1'b1, 28'd20, KIND_NOTEON, 4'd0, 8'd64, 14'd0));
      send_event(midi_ev(1'b0, 28'd5, KIND_NOTEON, 4'd0, 8'd64, 14'd1));
      wait_idle();
   endtask

   task automatic test_directed_events();
      write_threshold(8'sd64);
      send_event(midi_ev(1'b1, 28'd10, KIND_NOTEON, 4'd0, 8'd60, 14'd64));
      send_event(midi_ev(1'b0, 28'd5, KIND_NOTEON, 4'd0, 8'd60, 14'd65));
      send_event(midi_ev(1'b0, 28'd7, KIND_NOTEON, 4'd0, 8'd61, 14'd0));
      send_event(midi_ev(1'b0, 28'd3, KIND_NOTEOFF, 4'd1, 8'd60, 14'd0));
      send_event(midi_ev(1'b0, 28'd2, KIND_NOTEOFF, 4'd1, 8'd60, 14'd64));
      send_event(midi_ev(1'b0, 28'hFFFFFFF, KIND_NOTEOFF, 4'd1, 8'd61, 14'd0));
      send_event(midi_ev(1'b0, 28'hFFFFFFF, KIND_CONTROL, 4'd3, 8'd7, 14'd127));
      send_event(midi_ev(1'b0, 28'd0, KIND_CONTROL, 4'd3, 8'd10, 14'd0));
      send_event(midi_ev(1'b0, 28'd1, KIND_CONTROL, 4'd4, 8'd10, 14'd0));
      send_event(midi_ev(1'b0, 28'd1, KIND_POLYTOUCH, 4'd15, 8'd127, 14'h3FFF));
      send_event(midi_ev(1'b0, 28'd1, KIND_PROGRAM, 4'd15, 8'd99, 14'd5));
      send_event(midi_ev(1'b0, 28'd1, KIND_PRESSURE, 4'd15, 8'd12, 14'd100));
      send_event(midi_ev(1'b0, 28'd1, KIND_BEND, 4'd15, 8'd255, 14'h3FFF));
      send_event(midi_ev(1'b0, 28'd1, KIND_BEND, 4'd15, 8'd0, 14'd0));
      send_event(midi_ev(1'b0, 28'd9, KIND_SYSEX, 4'd9, 8'd33, 14'd100));
      send_event(midi_ev(1'b0, 28'd9, KIND_SYSEX, 4'd9, 8'd33, 14'd100));
      send_event(midi_ev(1'b0, 28'd4, KIND_META, 4'd0, 8'd255, 14'h3FFF));
      send_event(midi_ev(1'b0, 28'd4, KIND_META, 4'd0, 8'h2F, 14'd0));
      send_event(midi_ev(1'b0, 28'd8, KIND_NOTEON, 4'd2, 8'd200, 14'd0));
      send_event(midi_ev(1'b0, 28'd8, KIND_NOTEOFF, 4'd2, 8'd200, 14'd0));
      send_event(midi_ev(1'b0, 28'd6, KIND_NOTEON, 4'd2, 8'd255, 14'd64));
      send_event(midi_ev(1'b0, 28'd6, KIND_NOTEON, 4'd2, 8'd62, 14'd1));
      send_event(midi_ev(1'b0, 28'd3, KIND_CONTROL, 4'd3, 8'd1, 14'd2));
      send_event(midi_ev(1'b0, 28'd1000, KIND_UNKNOWN, 4'd5, 8'd62, 14'd9));
      send_event(midi_ev(1'b1, 28'd50, KIND_LAST, 4'd15, 8'd255, 14'h3FFF));
      send_event(midi_ev(1'b0, 28'd3, KIND_CONTROL, 4'd3, 8'd1, 14'd2));
      send_event(midi_ev(1'b0, 28'd3, KIND_NOTEOFF, 4'd0, 8'd62, 14'd0));
      wait_idle();
   endtask

   task automatic test_output_hold();
      @(posedge clock);
      hold_requests++;
      @(negedge clock);
      for (int i = 0; i < 30; i++) begin
         send_event(midi_ev(1'b0, 28'(i), KIND_CONTROL, 4'(i % 3), 8'(i), 14'(i * 7)));
      end
      wait_idle();
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input logic signed [THRESH_W-1:0] thr,
                                      input int count);
      set_idling(send_pct, stall_pct);
      wait_idle();
      write_threshold(thr);
      repeat (count) send_event(random_event());
      wait_idle();
   endtask

   task automatic test_count_run();
      set_idling(0, 0);
      write_threshold(8'sd0);
      send_event(midi_ev(1'b1, 28'($urandom), KIND_NOTEON, 4'($urandom), 8'd5, 14'd0));
      repeat (COUNT_RUN - 1) begin
         send_event(midi_ev(1'b0, 28'($urandom), KIND_NOTEON, 4'($urandom), 8'd5, 14'd0));
      end
      repeat (COUNT_RUN) begin
         send_event(midi_ev(1'b0, 28'($urandom), KIND_NOTEOFF, 4'($urandom), 8'd5, 14'd0));
      end
      send_event(midi_ev(1'b0, 28'($urandom), KIND_NOTEOFF, 4'd0, 8'd5, 14'd0));
      wait_idle();
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      set_idling(6, 51);
      test_reset_threshold();
      test_directed_events();
      test_output_hold();
      test_random_traffic(6, 51, 8'sd127, 200);
      test_random_traffic(51, 6, -8'sd1, 200);
      test_random_traffic(0, 0, 8'($urandom_range(126, 1)), 80);
      test_random_traffic(0, 0, 8'sd0, 80);
      test_count_run();
      wait_idle();
      if (mismatches == 0) begin
         $display("midi_low_velocity_note_filter test passed");
      end else begin
         $display("midi_low_velocity_note_filter test failed");
      end
      $finish;
   end

endmodule
